>>> src/tapid_pkg.sv
// Package for the three-axis PID position controller.
// Holds the item types, arithmetic widths, register codes and the microcode ROM.
// No dependencies.
package tapid_pkg;

    // Field and datapath widths.
    localparam int unsigned FIELD_W            = 32;
    localparam int unsigned GAIN_W             = 16;
    localparam int unsigned CFG_IDX_W          = 3;
    localparam int unsigned DATA_WIDTH_DEF     = 32;
    localparam int unsigned INTEGRAL_WIDTH_DEF = 48;
    localparam int unsigned ERR_W              = FIELD_W + 1;
    localparam int unsigned MUL_A_W            = ERR_W;
    localparam int unsigned MUL_B_W            = GAIN_W + 1;
    localparam int unsigned PROD_W             = MUL_A_W + MUL_B_W;
    localparam int unsigned RND_W              = PROD_W + 1;
    localparam int unsigned LO_W               = FIELD_W + GAIN_W;
    localparam int unsigned MAG_W              = 64;
    localparam int unsigned MAG_SPLIT          = 32;
    localparam int unsigned TERM_LOG2          = 52;
    localparam int unsigned TERM_W             = TERM_LOG2 + 1;
    localparam int unsigned HI_CLIP_BIT        = TERM_LOG2 - MAG_SPLIT;
    localparam int unsigned ACC_W              = 56;
    localparam int unsigned FRAC_SHIFT_INC     = 16;
    localparam int unsigned FRAC_SHIFT_OUT     = 8;
    localparam int unsigned HOVER_SHIFT        = 8;
    localparam int unsigned FORCE_W            = ACC_W - FRAC_SHIFT_OUT;
    localparam int unsigned PC_W               = 4;
    localparam int unsigned AXIS_W             = 2;
    localparam int unsigned NUM_AXES           = 3;

    localparam logic [AXIS_W-1:0] AXIS_X = 2'd0;
    localparam logic [AXIS_W-1:0] AXIS_Y = 2'd1;
    localparam logic [AXIS_W-1:0] AXIS_Z = 2'd2;

    // Register reset values.
    localparam logic [GAIN_W-1:0]         RST_GAIN_P  = 16'd2560;
    localparam logic [GAIN_W-1:0]         RST_GAIN_D  = 16'd2048;
    localparam logic [GAIN_W-1:0]         RST_GAIN_I  = 16'd1280;
    localparam logic signed [FIELD_W-1:0] RST_TGT_X   = 32'sd327680;
    localparam logic signed [FIELD_W-1:0] RST_TGT_Y   = 32'sd0;
    localparam logic signed [FIELD_W-1:0] RST_TGT_Z   = 32'sd32768;
    localparam logic signed [FIELD_W-1:0] RST_HOVER   = 32'sd642253;
    localparam logic [GAIN_W-1:0]         RST_STEP    = 16'd66;

    // Input and result words.
    typedef struct packed {
        logic signed [FIELD_W-1:0] pos_x;
        logic signed [FIELD_W-1:0] pos_y;
        logic signed [FIELD_W-1:0] pos_z;
        logic signed [FIELD_W-1:0] vel_x;
        logic signed [FIELD_W-1:0] vel_y;
        logic signed [FIELD_W-1:0] vel_z;
    } t_in_item;

    typedef struct packed {
        logic signed [FIELD_W-1:0] force_x;
        logic signed [FIELD_W-1:0] force_y;
        logic signed [FIELD_W-1:0] force_z;
        logic                      saturated;
    } t_out_item;

    // Configuration register indexes.
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_GAIN_P   = 3'd0,
        REG_GAIN_D   = 3'd1,
        REG_GAIN_I   = 3'd2,
        REG_TARGET_X = 3'd3,
        REG_TARGET_Y = 3'd4,
        REG_TARGET_Z = 3'd5,
        REG_HOVER    = 3'd6,
        REG_STEP     = 3'd7
    } t_reg_idx;

    // Multiplier operand selection.
    typedef enum logic [2:0] {
        MUL_NONE,
        MUL_E_STEP,
        MUL_E_KP,
        MUL_V_KD,
        MUL_MLO_KI,
        MUL_MHI_KI
    } t_mul_sel;

    // Datapath operation of one step.
    typedef enum logic [3:0] {
        ALU_NOP,
        ALU_LOAD_E,
        ALU_INTEG,
        ALU_ACC_INIT,
        ALU_ACC_SUB,
        ALU_SAVE_LO,
        ALU_ACC_TERM,
        ALU_ROUND,
        ALU_EMIT
    } t_alu_op;

    // Sequencer flow.
    typedef enum logic [1:0] {
        SEQ_NEXT,
        SEQ_LOOP,
        SEQ_END
    } t_seq_op;

    typedef struct packed {
        t_mul_sel mul;
        t_alu_op  alu;
        t_seq_op  seq;
    } t_uword;

    // Control handed from the sequencer to the datapath.
    typedef struct packed {
        logic                fire;
        t_uword              uw;
        logic [AXIS_W-1:0]   axis;
    } t_ctrl;

    // Microcode ROM: eight steps per axis, then one step that loads the result.
    function automatic t_uword ucode(input logic [PC_W-1:0] pc);
        t_uword w;
        unique case (pc)
            4'd0:    w = '{mul: MUL_NONE,   alu: ALU_LOAD_E,   seq: SEQ_NEXT};
            4'd1:    w = '{mul: MUL_E_STEP, alu: ALU_NOP,      seq: SEQ_NEXT};
            4'd2:    w = '{mul: MUL_E_KP,   alu: ALU_INTEG,    seq: SEQ_NEXT};
            4'd3:    w = '{mul: MUL_V_KD,   alu: ALU_ACC_INIT, seq: SEQ_NEXT};
            4'd4:    w = '{mul: MUL_MLO_KI, alu: ALU_ACC_SUB,  seq: SEQ_NEXT};
            4'd5:    w = '{mul: MUL_MHI_KI, alu: ALU_SAVE_LO,  seq: SEQ_NEXT};
            4'd6:    w = '{mul: MUL_NONE,   alu: ALU_ACC_TERM, seq: SEQ_NEXT};
            4'd7:    w = '{mul: MUL_NONE,   alu: ALU_ROUND,    seq: SEQ_LOOP};
            4'd8:    w = '{mul: MUL_NONE,   alu: ALU_EMIT,     seq: SEQ_END};
            default: w = '{mul: MUL_NONE,   alu: ALU_NOP,      seq: SEQ_END};
        endcase
        return w;
    endfunction

endpackage

>>> src/tapid_stream_if.sv
// Valid/ready stream interface carrying one word of a packed payload type.
// Payload types come from tapid_pkg; the interface itself has no dependencies.
interface tapid_stream_if #(
    parameter type T = logic
) ();
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

>>> src/three_axis_pid_position_controller.sv
// Three-axis PID position controller with a microcoded datapath around one shared multiplier.
// A 25-step program (8 steps per axis, 1 to load) runs from input acceptance to a valid result.
// A new tick is accepted only after the program ends, since input ready stays low while it runs;
// the program runs every product of the three axes through the single 33 x 17 multiplier.
// The load step waits while the output register holds a word that is not yet taken.
// Reset (synchronous, active low) loads the register defaults and clears the integrals.
module three_axis_pid_position_controller
    import tapid_pkg::*;
#(
    parameter int unsigned DATA_WIDTH     = DATA_WIDTH_DEF,
    parameter int unsigned INTEGRAL_WIDTH = INTEGRAL_WIDTH_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [FIELD_W-1:0]   i_cfg_data,
    tapid_stream_if.sink         i_in,
    tapid_stream_if.source       o_out
);

    localparam int unsigned IW    = INTEGRAL_WIDTH;
    localparam int unsigned SUM_W = IW + 3;

    // Configuration registers.
    logic [GAIN_W-1:0]         r_gain_p, r_gain_d, r_gain_i, r_step;
    logic signed [FIELD_W-1:0] r_tgt [NUM_AXES];
    logic signed [FIELD_W-1:0] r_hover;

    // Input word, working registers and kept state.
    logic signed [FIELD_W-1:0] r_pos [NUM_AXES];
    logic signed [FIELD_W-1:0] r_vel [NUM_AXES];
    logic signed [ERR_W-1:0]   r_e;
    logic signed [PROD_W-1:0]  r_prod;
    logic [LO_W-1:0]           r_lo;
    logic signed [ACC_W-1:0]   r_acc;
    logic signed [IW-1:0]      r_integ [NUM_AXES];
    logic signed [FIELD_W-1:0] r_force [NUM_AXES];
    logic                      r_clip;
    logic                      r_out_valid;
    t_out_item                 r_out_data;

    t_ctrl                     ctrl;
    logic                      busy;
    logic                      in_acc;
    logic                      out_free;
    logic [AXIS_W-1:0]         ax;
    t_in_item                  in_word;

    logic signed [IW-1:0]      integ_sel;
    logic [MAG_W-1:0]          integ_ext, mag;
    logic signed [MUL_A_W-1:0] mul_a;
    logic signed [MUL_B_W-1:0] mul_b;
    logic signed [PROD_W-1:0]  prod;

    logic signed [RND_W-1:0]   inc_rnd, inc_full;
    logic signed [SUM_W-1:0]   inc_s, sum_i;
    logic                      integ_fits;
    logic signed [IW-1:0]      integ_next, i_max, i_min;

    logic signed [ACC_W-1:0]   hover_term, acc_init, acc_sub, acc_term, term_s;
    logic [LO_W-1:0]           hi_prod;
    logic [TERM_W-1:0]         psum, term_mag;
    logic                      hi_big;
    localparam logic [TERM_W-1:0] TERM_LIMIT = {1'b1, {TERM_LOG2{1'b0}}};

    logic signed [ACC_W-1:0]   f_rnd;
    logic signed [FORCE_W-1:0] f_val, f_sat, f_max, f_min;
    logic                      f_fits;

    assign in_word  = i_in.data;
    assign in_acc   = i_in.valid && i_in.ready;
    assign out_free = !r_out_valid || o_out.ready;
    assign i_in.ready  = !busy;
    assign o_out.valid = r_out_valid;
    assign o_out.data  = r_out_data;

    tapid_seq u_seq (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (in_acc),
        .i_out_free (out_free),
        .o_busy     (busy),
        .o_ctrl     (ctrl)
    );

    assign ax = ctrl.axis;

    // Configuration write port.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gain_p      <= RST_GAIN_P;
            r_gain_d      <= RST_GAIN_D;
            r_gain_i      <= RST_GAIN_I;
            r_tgt[AXIS_X] <= RST_TGT_X;
            r_tgt[AXIS_Y] <= RST_TGT_Y;
            r_tgt[AXIS_Z] <= RST_TGT_Z;
            r_hover       <= RST_HOVER;
            r_step        <= RST_STEP;
        end else if (i_cfg_we) begin
            unique case (t_reg_idx'(i_cfg_idx))
                REG_GAIN_P:   r_gain_p      <= i_cfg_data[GAIN_W-1:0];
                REG_GAIN_D:   r_gain_d      <= i_cfg_data[GAIN_W-1:0];
                REG_GAIN_I:   r_gain_i      <= i_cfg_data[GAIN_W-1:0];
                REG_TARGET_X: r_tgt[AXIS_X] <= i_cfg_data;
                REG_TARGET_Y: r_tgt[AXIS_Y] <= i_cfg_data;
                REG_TARGET_Z: r_tgt[AXIS_Z] <= i_cfg_data;
                REG_HOVER:    r_hover       <= i_cfg_data;
                REG_STEP:     r_step        <= i_cfg_data[GAIN_W-1:0];
                default:      r_step        <= r_step;
            endcase
        end
    end

    // Magnitude of the current axis integral, split later into two 32-bit halves.
    assign integ_sel = r_integ[ax];
    assign integ_ext = MAG_W'(integ_sel);
    assign mag       = integ_sel[IW-1] ? (MAG_W'(0) - integ_ext) : integ_ext;

    // Shared multiplier operand selection.
    always_comb begin
        unique case (ctrl.uw.mul)
            MUL_E_STEP: begin
                mul_a = r_e;
                mul_b = signed'({1'b0, r_step});
            end
            MUL_E_KP: begin
                mul_a = r_e;
                mul_b = signed'({1'b0, r_gain_p});
            end
            MUL_V_KD: begin
                mul_a = MUL_A_W'(r_vel[ax]);
                mul_b = signed'({1'b0, r_gain_d});
            end
            MUL_MLO_KI: begin
                mul_a = signed'({1'b0, mag[MAG_SPLIT-1:0]});
                mul_b = signed'({1'b0, r_gain_i});
            end
            MUL_MHI_KI: begin
                mul_a = signed'({1'b0, mag[MAG_W-1:MAG_SPLIT]});
                mul_b = signed'({1'b0, r_gain_i});
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign prod = PROD_W'(mul_a) * PROD_W'(mul_b);

    // Integral update: round e*step to Q.16 and add with saturation.
    assign inc_rnd    = RND_W'(r_prod) + RND_W'(1 << (FRAC_SHIFT_INC - 1));
    assign inc_full   = inc_rnd >>> FRAC_SHIFT_INC;
    assign inc_s      = SUM_W'(inc_full);
    assign sum_i      = SUM_W'(integ_sel) + inc_s;
    assign integ_fits = (&sum_i[SUM_W-1:IW-1]) || !(|sum_i[SUM_W-1:IW-1]);
    assign i_max      = signed'({1'b0, {(IW-1){1'b1}}});
    assign i_min      = signed'({1'b1, {(IW-1){1'b0}}});
    assign integ_next = integ_fits ? sum_i[IW-1:0] : (sum_i[SUM_W-1] ? i_min : i_max);

    // Accumulator steps: start with -kp*e plus hover on z, then subtract kd*v.
    assign hover_term = (ax == AXIS_Z) ? (ACC_W'(r_hover) <<< HOVER_SHIFT) : '0;
    assign acc_init   = hover_term - ACC_W'(r_prod);
    assign acc_sub    = r_acc - ACC_W'(r_prod);

    // Integral term: ki*|integral| clipped at 2^52, sign taken from the integral.
    assign hi_prod  = r_prod[LO_W-1:0];
    assign hi_big   = |hi_prod[LO_W-1:HI_CLIP_BIT];
    assign psum     = TERM_W'({hi_prod[HI_CLIP_BIT-1:0], {MAG_SPLIT{1'b0}}}) + TERM_W'(r_lo);
    assign term_mag = (hi_big || (psum > TERM_LIMIT)) ? TERM_LIMIT : psum;
    assign term_s   = signed'(ACC_W'(term_mag));
    assign acc_term = integ_sel[IW-1] ? (r_acc + term_s) : (r_acc - term_s);

    // Output rounding to Q16.16 and saturation to the data width.
    assign f_rnd  = r_acc + ACC_W'(1 << (FRAC_SHIFT_OUT - 1));
    assign f_val  = FORCE_W'(f_rnd >>> FRAC_SHIFT_OUT);
    assign f_fits = (&f_val[FORCE_W-1:DATA_WIDTH-1]) || !(|f_val[FORCE_W-1:DATA_WIDTH-1]);
    assign f_max  = signed'({{(FORCE_W-DATA_WIDTH+1){1'b0}}, {(DATA_WIDTH-1){1'b1}}});
    assign f_min  = ~f_max;
    assign f_sat  = f_fits ? f_val : (f_val[FORCE_W-1] ? f_min : f_max);

    // Input capture.
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_pos[AXIS_X] <= in_word.pos_x;
            r_pos[AXIS_Y] <= in_word.pos_y;
            r_pos[AXIS_Z] <= in_word.pos_z;
            r_vel[AXIS_X] <= in_word.vel_x;
            r_vel[AXIS_Y] <= in_word.vel_y;
            r_vel[AXIS_Z] <= in_word.vel_z;
        end
    end

    // Datapath payload registers driven by the current control word.
    always_ff @(posedge i_clk) begin
        if (ctrl.fire && (ctrl.uw.mul != MUL_NONE)) begin
            r_prod <= prod;
        end
        if (ctrl.fire) begin
            unique case (ctrl.uw.alu)
                ALU_LOAD_E:   r_e         <= ERR_W'(r_pos[ax]) - ERR_W'(r_tgt[ax]);
                ALU_ACC_INIT: r_acc       <= acc_init;
                ALU_ACC_SUB:  r_acc       <= acc_sub;
                ALU_SAVE_LO:  r_lo        <= r_prod[LO_W-1:0];
                ALU_ACC_TERM: r_acc       <= acc_term;
                ALU_ROUND:    r_force[ax] <= f_sat[FIELD_W-1:0];
                ALU_EMIT:     r_out_data  <= '{force_x:   r_force[AXIS_X],
                                               force_y:   r_force[AXIS_Y],
                                               force_z:   r_force[AXIS_Z],
                                               saturated: r_clip};
                default:      r_lo        <= r_lo;
            endcase
        end
    end

    // Kept integrals, clip flag and output valid.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_integ[AXIS_X] <= '0;
            r_integ[AXIS_Y] <= '0;
            r_integ[AXIS_Z] <= '0;
            r_clip          <= 1'b0;
            r_out_valid     <= 1'b0;
        end else begin
            if (in_acc) begin
                r_clip <= 1'b0;
            end else if (ctrl.fire && (ctrl.uw.alu == ALU_INTEG)) begin
                r_integ[ax] <= integ_next;
                if (!integ_fits) begin
                    r_clip <= 1'b1;
                end
            end else if (ctrl.fire && (ctrl.uw.alu == ALU_ROUND) && !f_fits) begin
                r_clip <= 1'b1;
            end
            if (ctrl.fire && (ctrl.uw.alu == ALU_EMIT)) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

endmodule

>>> src/tapid_seq.sv
// Microcode sequencer: step counter, axis counter and ROM lookup.
// Depends on tapid_pkg for the control word and the ROM function.
module tapid_seq
    import tapid_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_start,
    input  logic  i_out_free,
    output logic  o_busy,
    output t_ctrl o_ctrl
);

    logic              r_busy, n_busy;
    logic [PC_W-1:0]   r_pc, n_pc;
    logic [AXIS_W-1:0] r_axis, n_axis;
    t_uword            uw;
    logic              fire;

    // The final step waits until the output register can take the result.
    assign uw   = ucode(r_pc);
    assign fire = r_busy && ((uw.seq != SEQ_END) || i_out_free);

    // Next step: advance, loop back for the next axis, or finish.
    always_comb begin
        n_busy = r_busy;
        n_pc   = r_pc;
        n_axis = r_axis;
        if (i_start) begin
            n_busy = 1'b1;
            n_pc   = '0;
            n_axis = AXIS_X;
        end else if (fire) begin
            unique case (uw.seq)
                SEQ_NEXT: begin
                    n_pc = r_pc + 1'b1;
                end
                SEQ_LOOP: begin
                    if (r_axis == AXIS_Z) begin
                        n_pc = r_pc + 1'b1;
                    end else begin
                        n_axis = r_axis + 1'b1;
                        n_pc   = '0;
                    end
                end
                SEQ_END: begin
                    n_busy = 1'b0;
                    n_pc   = '0;
                    n_axis = AXIS_X;
                end
                default: begin
                    n_busy = 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_pc   <= '0;
            r_axis <= AXIS_X;
        end else begin
            r_busy <= n_busy;
            r_pc   <= n_pc;
            r_axis <= n_axis;
        end
    end

    assign o_busy = r_busy;
    assign o_ctrl = '{fire: fire, uw: uw, axis: r_axis};

endmodule
